// File: hdl/u8d_pkg.sv
`timescale 1ns / 1ps

package u8d_pkg;

    // field widths
    localparam int CP_W  = 21;
    localparam int LEN_W = 3;

    typedef logic [CP_W-1:0]  cp_t;
    typedef logic [LEN_W-1:0] len_t;

    // one decoded result
    typedef struct packed {
        cp_t  code_point;
        logic is_error;
        len_t bytes_used;
        logic last_of_run;
    } result_t;

    // open sequence: gathered bits, announced length (0 = none), bytes so far
    typedef struct packed {
        cp_t  partial;
        len_t expected;
        len_t collected;
    } seq_state_t;

    // up to two results from one byte
    typedef struct packed {
        logic    v0;
        result_t r0;
        logic    v1;
        result_t r1;
    } step_out_t;

    // byte classes
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_BASE  = 8'hC0;
    localparam logic [7:0] LEAD3_BASE  = 8'hE0;
    localparam logic [7:0] LEAD4_BASE  = 8'hF0;
    localparam logic [7:0] LEAD_BAD    = 8'hF8;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_MARK   = 8'h80;

    // sequence lengths
    localparam len_t LEN_NONE = 3'd0;
    localparam len_t LEN_ONE  = 3'd1;
    localparam len_t LEN_TWO  = 3'd2;
    localparam len_t LEN_THREE = 3'd3;
    localparam len_t LEN_FOUR = 3'd4;

    // scalar value limits
    localparam cp_t MIN_TWO   = 21'h000080;
    localparam cp_t MIN_THREE = 21'h000800;
    localparam cp_t MIN_FOUR  = 21'h010000;
    localparam cp_t SURR_LO   = 21'h00D800;
    localparam cp_t SURR_HI   = 21'h00DFFF;
    localparam cp_t CP_MAX    = 21'h10FFFF;

    // register file
    localparam int  ADDR_W     = 3;
    localparam logic REG_REPL  = 1'b0;     // word index of replacement_code
    localparam cp_t REPL_RESET = 21'h00FFFD;

    // result queue
    localparam int RES_DEPTH = 4;
    localparam int PTR_W     = 2;
    localparam int CNT_W     = 3;

endpackage

// File: hdl/utf8_stream_decoder.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | byte_in[7:0], end_of_text
// out     | output    | out_valid/out_stall| code_point[20:0], is_error, bytes_used[2:0],
//         |           |                    | last_of_run
// cfg     | input     | APB write/read     | replacement_code at address 0
//
// One byte is taken per cycle while in_stall is low; its results enter a four-entry
// result queue at the same edge and can leave from the next cycle on, one per cycle
// while out_stall is low. A byte that yields two results puts both in the queue, so the
// queue drain rate of one result per cycle sets the sustained rate for such bytes.
// in_stall rises when the queue holds three or more results.
// Reset clears the open sequence and the queue and loads replacement_code with FFFD.

module utf8_stream_decoder (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [u8d_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // byte requests
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   byte_in,
    input  logic                         end_of_text,
    // result requests
    output logic                         out_valid,
    input  logic                         out_stall,
    output u8d_pkg::cp_t                 code_point,
    output logic                         is_error,
    output u8d_pkg::len_t                bytes_used,
    output logic                         last_of_run
);
    import u8d_pkg::*;

    cp_t        repl_reg;
    seq_state_t seq_reg;
    seq_state_t seq_next;
    step_out_t  step_res;
    result_t    queue_reg [RES_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] push_n;
    logic       accept;
    logic       pop;
    result_t    head;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_REPL) ? {11'd0, repl_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_reg <= REPL_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_REPL)
        begin
            repl_reg <= pwdata[CP_W-1:0];
        end
    end

    // per-byte decode
    u8d_step u_step (
        .byte_in     (byte_in),
        .end_of_text (end_of_text),
        .repl        (repl_reg),
        .cur         (seq_reg),
        .nxt         (seq_next),
        .res         (step_res)
    );

    assign in_stall = count_reg > CNT_W'(RES_DEPTH - 2);
    assign accept   = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= '0;
        end
        else if (accept)
        begin
            seq_reg <= seq_next;
        end
    end

    // result queue
    assign push_n     = accept ? (CNT_W'(step_res.v0) + CNT_W'(step_res.v1)) : '0;
    assign count_next = count_reg + push_n - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (accept && step_res.v0)
        begin
            queue_reg[wr_ptr_reg] <= step_res.r0;
        end
        if (accept && step_res.v1)
        begin
            queue_reg[wr_ptr_reg + PTR_W'(1)] <= step_res.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_n[PTR_W-1:0];
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    assign head        = queue_reg[rd_ptr_reg];
    assign out_valid   = count_reg != '0;
    assign code_point  = head.code_point;
    assign is_error    = head.is_error;
    assign bytes_used  = head.bytes_used;
    assign last_of_run = head.last_of_run;

    // checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RES_DEPTH))
        else $error("result queue overfilled");

    a_valid_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_error |->
            !(code_point >= SURR_LO && code_point <= SURR_HI) && code_point <= CP_MAX)
        else $error("clean result is not a scalar value");

    a_single_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_error && bytes_used == LEN_ONE |-> code_point < MIN_TWO)
        else $error("one-byte result above 7F");

endmodule

// File: hdl/u8d_step.sv
`timescale 1ns / 1ps

module u8d_step (
    input  logic [7:0]          byte_in,
    input  logic                end_of_text,
    input  u8d_pkg::cp_t        repl,
    input  u8d_pkg::seq_state_t cur,
    output u8d_pkg::seq_state_t nxt,
    output u8d_pkg::step_out_t  res
);
    import u8d_pkg::*;

    logic       s_emit;
    result_t    s_res;
    seq_state_t s_state;
    cp_t        cont_pv;
    len_t       cont_cnt;
    logic       cont_done;
    cp_t        minimum;
    logic       bad;
    logic       is_cont;
    seq_state_t pre;

    // byte seen with no sequence open
    always_comb
    begin
        s_emit  = 1'b0;
        s_res   = '{code_point: repl, is_error: 1'b1, bytes_used: LEN_ONE,
                    last_of_run: 1'b1};
        s_state = '0;
        priority if (byte_in < ASCII_LIMIT)
        begin
            s_emit            = 1'b1;
            s_res.code_point  = {13'd0, byte_in};
            s_res.is_error    = 1'b0;
        end
        else if (byte_in < LEAD2_BASE || byte_in >= LEAD_BAD)
        begin
            s_emit = 1'b1;
        end
        else if (byte_in < LEAD3_BASE)
        begin
            s_state = '{partial: {16'd0, byte_in[4:0]}, expected: LEN_TWO,
                        collected: LEN_ONE};
        end
        else if (byte_in < LEAD4_BASE)
        begin
            s_state = '{partial: {17'd0, byte_in[3:0]}, expected: LEN_THREE,
                        collected: LEN_ONE};
        end
        else
        begin
            s_state = '{partial: {18'd0, byte_in[2:0]}, expected: LEN_FOUR,
                        collected: LEN_ONE};
        end
    end

    // continuation: shift in six bits and check for completion
    assign is_cont   = (byte_in & CONT_MASK) == CONT_MARK;
    assign cont_pv   = {cur.partial[14:0], byte_in[5:0]};
    assign cont_cnt  = cur.collected + LEN_ONE;
    assign cont_done = cont_cnt >= cur.expected;

    always_comb
    begin
        unique case (cur.expected)
            LEN_TWO:   minimum = MIN_TWO;
            LEN_THREE: minimum = MIN_THREE;
            default:   minimum = MIN_FOUR;
        endcase
    end

    assign bad = (cont_pv < minimum) || (cont_pv >= SURR_LO && cont_pv <= SURR_HI)
                 || (cont_pv > CP_MAX);

    // sequence update and results
    always_comb
    begin
        pre = cur;
        res = '0;
        priority if (byte_in == 8'h00)
        begin
            pre = '0;
        end
        else if (cur.expected == LEN_NONE)
        begin
            pre    = s_state;
            res.v0 = s_emit;
            res.r0 = s_res;
        end
        else if (is_cont)
        begin
            if (cont_done)
            begin
                pre    = '0;
                res.v0 = 1'b1;
                res.r0 = '{code_point: bad ? repl : cont_pv, is_error: bad,
                           bytes_used: cur.expected, last_of_run: 1'b1};
            end
            else
            begin
                pre = '{partial: cont_pv, expected: cur.expected,
                        collected: cont_cnt};
            end
        end
        else
        begin
            // interrupted sequence, then the byte starts afresh
            pre    = s_state;
            res.v0 = 1'b1;
            res.r0 = '{code_point: repl, is_error: 1'b1,
                       bytes_used: cur.collected, last_of_run: !s_emit};
            res.v1 = s_emit;
            res.r1 = s_res;
        end
    end

    // end of text drops a sequence still open
    assign nxt = (end_of_text && pre.expected != LEN_NONE) ? '0 : pre;

endmodule
